@@ hw/rtl/mte_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mte_pkg: shared types and constants for the MIDI track event encoder
// Payload structs, command codes, register indexes, queue entry layout.
// ============================================================================
package mte_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [2:0] CMD_TEMPO    = 3'd2;
  localparam logic [2:0] CMD_TIME_SIG = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_BPM      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_BEATS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_BASE       = 2'd3;

  // Register reset values
  localparam logic [9:0]  TEMPO_BPM_RST      = 10'd120;
  localparam logic [14:0] TICKS_PER_BEAT_RST = 15'd480;
  localparam logic [7:0]  SIG_BEATS_RST      = 8'd4;
  localparam logic [7:0]  SIG_BASE_RST       = 8'd4;

  // Tempo divider: microseconds per minute over bpm
  localparam int          TEMPO_NUM_W = 26;
  localparam logic [TEMPO_NUM_W-1:0] TEMPO_NUM = 26'd60000000;
  localparam int          DIV_STEPS   = TEMPO_NUM_W;
  localparam logic [9:0]  TEMPO_MIN   = 10'd4;
  localparam logic [23:0] TEMPO_SAT   = 24'hFFFFFF;

  // x/3 for 15-bit x as (x * ceil(2^17/3)) >> 17
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int          RECIP3_SHIFT = 17;

  // Event byte constants
  localparam logic [7:0] META_BYTE    = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] LEN_TEMPO    = 8'h03;
  localparam logic [7:0] LEN_TIMESIG  = 8'h04;
  localparam logic [7:0] SIG_32ND     = 8'h08;
  localparam logic [3:0] STATUS_ON    = 4'h9;
  localparam logic [3:0] STATUS_OFF   = 4'h8;

  // Queue entry layout
  localparam int ENTRY_BYTES = 8;
  localparam int BYTE_IDX_W  = $clog2(ENTRY_BYTES);
  localparam int VLQ_GROUPS  = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [27:0] delta_ticks;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
  } mte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } mte_out_t;

  typedef struct packed {
    logic [ENTRY_BYTES-1:0][7:0] bytes;
    logic [BYTE_IDX_W-1:0]       last_idx;
  } mte_entry_t;

  // Queue status seen by front (full) and back (empty)
  typedef struct packed {
    logic full;
    logic empty;
  } mte_qstat_t;

  // Tempo divider status and result
  typedef struct packed {
    logic        busy;
    logic [23:0] quot;
  } mte_tempo_t;

endpackage

@@ hw/rtl/mte_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mte_div: tempo quotient divider
// Restoring divide of the fixed numerator by tempo_bpm, one bit per cycle.
// Restarts at reset and on every tempo_bpm write.
// ============================================================================
module mte_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [9:0]        divisor,
  output mte_pkg::mte_tempo_t tempo
);
  import mte_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [9:0]             rem;
  logic [TEMPO_NUM_W-1:0] qr;
  logic [10:0]            rem_sh;
  logic                   fits;

  // one restoring step
  assign rem_sh = {rem, qr[TEMPO_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      qr   <= TEMPO_NUM;
    end else if (busy) begin
      rem <= fits ? 10'(rem_sh - {1'b0, divisor}) : rem_sh[9:0];
      qr  <= {qr[TEMPO_NUM_W-2:0], fits};
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign tempo.busy = busy;
  assign tempo.quot = qr[23:0];

endmodule

@@ hw/rtl/mte_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mte_front: event classifier
// Accepts one event per unstalled cycle and lays out its full byte sequence as a
// queue entry; dropped events (unknown command, bad denominator) never enqueue.
// ============================================================================
module mte_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mte_pkg::mte_in_t     in_data,
  input  logic [9:0]           tempo_bpm,
  input  logic [14:0]          ticks_per_beat,
  input  logic [7:0]           sig_beats,
  input  logic [7:0]           sig_base,
  input  mte_pkg::mte_tempo_t  tempo,
  input  mte_pkg::mte_qstat_t  qstat,
  output logic                 push,
  output mte_pkg::mte_entry_t  push_entry
);
  import mte_pkg::*;

  logic                          accept;
  logic                          keep;
  logic [VLQ_GROUPS-1:0][6:0]    grp;
  logic [2:0]                    vlq_n;
  logic [1:0]                    gi;
  logic [23:0]                   q;
  logic [7:0]                    lg;
  logic                          base_ok;
  logic [30:0]                   prod3;
  logic [7:0]                    clocks;
  mte_entry_t                    ent;

  // hold off input while queue is full or the tempo quotient is settling
  assign in_stall = qstat.full || tempo.busy;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && keep;
  assign push_entry = ent;

  // delta time split into 7-bit groups, count of significant groups
  assign grp = in_data.delta_ticks;
  always_comb begin
    if (grp[3] != '0)      vlq_n = 3'd4;
    else if (grp[2] != '0) vlq_n = 3'd3;
    else if (grp[1] != '0) vlq_n = 3'd2;
    else                   vlq_n = 3'd1;
  end

  // tempo quotient with saturation for very slow tempos
  assign q = (tempo_bpm < TEMPO_MIN) ? TEMPO_SAT : tempo.quot;

  // denominator to log2
  always_comb begin
    base_ok = 1'b1;
    case (sig_base)
      8'd1:    lg = 8'd0;
      8'd2:    lg = 8'd1;
      8'd4:    lg = 8'd2;
      8'd8:    lg = 8'd3;
      8'd16:   lg = 8'd4;
      8'd32:   lg = 8'd5;
      default: begin
        lg      = 8'd0;
        base_ok = 1'b0;
      end
    endcase
  end

  // time signature metronome byte: ticks_per_beat / 3 for eighth-note base, else ticks_per_beat
  assign prod3  = 31'(ticks_per_beat) * 31'(RECIP3);
  assign clocks = (sig_base == 8'd8) ? prod3[RECIP3_SHIFT+7:RECIP3_SHIFT]
                                     : ticks_per_beat[7:0];

  // byte sequence layout
  always_comb begin
    ent  = '0;
    keep = 1'b1;
    gi   = '0;
    case (in_data.cmd)
      CMD_NOTE_ON, CMD_NOTE_OFF: begin
        for (int k = 0; k < VLQ_GROUPS; k++) begin
          if (3'(k) < vlq_n) begin
            gi = 2'(vlq_n - 3'(k) - 3'd1);
            ent.bytes[k] = {(3'(k) != (vlq_n - 3'd1)), grp[gi]};
          end
        end
        ent.bytes[vlq_n] = {(in_data.cmd == CMD_NOTE_ON) ? STATUS_ON : STATUS_OFF,
                            in_data.channel};
        ent.bytes[3'(vlq_n + 3'd1)] = {1'b0, in_data.pitch};
        ent.bytes[3'(vlq_n + 3'd2)] = (in_data.cmd == CMD_NOTE_ON)
                                      ? {1'b0, in_data.velocity} : 8'h00;
        ent.last_idx = 3'(vlq_n + 3'd2);
      end
      CMD_TEMPO: begin
        ent.bytes[1] = META_BYTE;
        ent.bytes[2] = META_TEMPO;
        ent.bytes[3] = LEN_TEMPO;
        ent.bytes[4] = q[23:16];
        ent.bytes[5] = q[15:8];
        ent.bytes[6] = q[7:0];
        ent.last_idx = 3'd6;
      end
      CMD_TIME_SIG: begin
        ent.bytes[1] = META_BYTE;
        ent.bytes[2] = META_TIMESIG;
        ent.bytes[3] = LEN_TIMESIG;
        ent.bytes[4] = sig_beats;
        ent.bytes[5] = lg;
        ent.bytes[6] = clocks;
        ent.bytes[7] = SIG_32ND;
        ent.last_idx = 3'd7;
        keep = base_ok;
      end
      CMD_END: begin
        ent.bytes[1] = META_BYTE;
        ent.bytes[2] = META_EOT;
        ent.last_idx = 3'd3;
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/mte_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mte_queue: event queue between classifier and byte sequencer
// Small FIFO of complete byte sequences.
// ============================================================================
module mte_queue #(
  parameter int DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mte_pkg::mte_entry_t  push_entry,
  input  logic                 pop,
  output mte_pkg::mte_entry_t  head,
  output mte_pkg::mte_qstat_t  qstat
);
  import mte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mte_entry_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= CNT_W'(count + CNT_W'(push) - CNT_W'(pop));
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/mte_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mte_back: byte sequencer
// Walks the head queue entry one byte per unstalled cycle into the output
// register and retires the entry with its final byte.
// ============================================================================
module mte_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mte_pkg::mte_entry_t  head,
  input  mte_pkg::mte_qstat_t  qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mte_pkg::mte_out_t    out_data
);
  import mte_pkg::*;

  logic [BYTE_IDX_W-1:0] idx;
  logic                  load;
  logic                  at_last;

  // load the output register from a non-empty queue when it is empty or being taken
  assign load    = !qstat.empty && (!out_valid || !out_stall);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte  <= head.bytes[idx];
      out_data.last_byte <= at_last;
    end
  end

endmodule

@@ hw/rtl/midi_track_event_encoder_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// midi_track_event_encoder_core: MIDI track event byte encoder
// Turns note, tempo, time signature and end-of-track events into their
// standard MIDI file byte sequences, one byte per output transaction.
// ============================================================================
// Events are taken at up to one per cycle into a short queue and leave at one
// byte per cycle while out_stall is low, so the output byte sequencer and each
// event's byte count set the sustained rate: 4 to 7 bytes for notes (1 to 4
// delta-time bytes plus 3), 7 for tempo, 8 for time signature, 4 for end of
// track. Dropped events (unknown command, time signature with a denominator
// other than 1, 2, 4, 8, 16 or 32) are taken and give nothing. The tempo
// quotient comes from a bit-serial divider that runs after reset and after each
// tempo_bpm write; input is stalled while it runs or while the queue is full.
// Configuration writes are always ready and take effect the next cycle.
// ============================================================================
module midi_track_event_encoder_core #(
  parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mte_pkg::mte_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mte_pkg::mte_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mte_pkg::*;

  logic [9:0]  tempo_bpm;
  logic [14:0] ticks_per_beat;
  logic [7:0]  sig_beats;
  logic [7:0]  sig_base;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  mte_entry_t  push_entry;
  mte_entry_t  head;
  mte_qstat_t  qstat;
  mte_tempo_t  tempo;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_bpm      <= TEMPO_BPM_RST;
      ticks_per_beat <= TICKS_PER_BEAT_RST;
      sig_beats      <= SIG_BEATS_RST;
      sig_base       <= SIG_BASE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_TEMPO_BPM:      tempo_bpm      <= cfg_data[9:0];
        CFG_TICKS_PER_BEAT: ticks_per_beat <= cfg_data[14:0];
        CFG_SIG_BEATS:      sig_beats      <= cfg_data[7:0];
        CFG_SIG_BASE:       sig_base       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mte_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_wr && (cfg_index == CFG_TEMPO_BPM)),
    .divisor (tempo_bpm),
    .tempo   (tempo)
  );

  mte_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .tempo_bpm      (tempo_bpm),
    .ticks_per_beat (ticks_per_beat),
    .sig_beats      (sig_beats),
    .sig_base       (sig_base),
    .tempo          (tempo),
    .qstat          (qstat),
    .push           (push),
    .push_entry     (push_entry)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  mte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ dv/midi_track_event_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// midi_track_event_encoder_core_tb: self-checking bench for the event encoder
// Drives note, tempo, time signature, end-of-track and unknown events through
// the valid/stall input, predicts each encoded byte stream in the bench or takes
// it typed from the table, and compares every output transaction against it. A
// directed table comes first, then random traffic over several register settings
// and handshake mixes, including a long output hold that backs the block up.
// ============================================================================
module midi_track_event_encoder_core_tb;
  import mte_pkg::*;

  localparam int SETTLE_CYCLES = 64;      // divider run plus queue and sequencer
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int MAX_PRINTED   = 40;

  // One row of the directed table: either a full register set or one event
  typedef struct {
    bit                 is_cfg;
    logic [3:0][14:0]   regs;
    mte_in_t            ev;
    int                 n_typed;          // -1: use the predictor
    logic [0:7][7:0]    typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mte_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mte_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the registers
  logic [9:0]  bpm_mirror   = 10'd120;
  logic [14:0] ticks_mirror = 15'd480;
  logic [7:0]  beats_mirror = 8'd4;
  logic [7:0]  base_mirror  = 8'd4;

  // Typed expectation that rides along with the event on offer
  int              typed_n = -1;
  logic [0:7][7:0] typed_bytes = '0;

  mte_out_t expected_bytes[$];
  stim_row_t directed_rows[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_armed = 1'b0;
  logic hold_on = 1'b0;

  int mismatch_count = 0;
  int events_taken = 0;
  int events_silent = 0;
  int bytes_checked = 0;
  int settings_count = 0;
  int cycle_count = 0;

  midi_track_event_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_count,
               expected_bytes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  // Byte stream of one event under the current register values
  function automatic void encode_event(input mte_in_t ev);
    logic [7:0]  seq[$];
    int          groups;
    int unsigned quot;
    logic [7:0]  lg;
    logic [14:0] clocks;
    case (ev.cmd)
      CMD_NOTE_ON, CMD_NOTE_OFF: begin
        // delta time, 7-bit groups MSB first, continuation bit on all but last
        groups = 1;
        while (groups < 4 && (ev.delta_ticks >> (7 * groups)) != 0) groups++;
        for (int g = groups - 1; g >= 0; g--)
          seq.push_back({g != 0, ev.delta_ticks[7 * g +: 7]});
        seq.push_back({(ev.cmd == CMD_NOTE_ON) ? 4'h9 : 4'h8, ev.channel});
        seq.push_back({1'b0, ev.pitch});
        seq.push_back((ev.cmd == CMD_NOTE_ON) ? {1'b0, ev.velocity} : 8'h00);
      end
      CMD_TEMPO: begin
        // slow tempo saturates the 24-bit quotient
        quot = (bpm_mirror < 10'd4) ? 32'hFF_FFFF : 60_000_000 / bpm_mirror;
        seq = '{8'h00, 8'hFF, 8'h51, 8'h03, quot[23:16], quot[15:8], quot[7:0]};
      end
      CMD_TIME_SIG: begin
        case (base_mirror)
          8'd1:  lg = 8'd0;
          8'd2:  lg = 8'd1;
          8'd4:  lg = 8'd2;
          8'd8:  lg = 8'd3;
          8'd16: lg = 8'd4;
          8'd32: lg = 8'd5;
          default: return;  // bad denominator: nothing
        endcase
        clocks = (lg == 8'd3) ? ticks_mirror / 3 : ticks_mirror;
        seq = '{8'h00, 8'hFF, 8'h58, 8'h04, beats_mirror, lg, clocks[7:0], 8'h08};
      end
      CMD_END: seq = '{8'h00, 8'hFF, 8'h2F, 8'h00};
      default: return;       // unknown command: nothing
    endcase
    foreach (seq[i])
      expected_bytes.push_back(mte_out_t'({seq[i], i == seq.size() - 1}));
  endfunction

  // Input and output transaction monitor
  always @(posedge clk) begin : monitor
    mte_out_t want;
    int depth_before;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        events_taken++;
        depth_before = expected_bytes.size();
        if (typed_n < 0)
          encode_event(in_data);
        else
          for (int i = 0; i < typed_n; i++)
            expected_bytes.push_back(mte_out_t'({typed_bytes[i], i == typed_n - 1}));
        if (expected_bytes.size() == depth_before) events_silent++;
      end
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b", out_data.out_byte,
                                    out_data.last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_data.out_byte,
                                      want.out_byte));
          if (out_data.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                      out_data.last_byte, want.last_byte, want.out_byte));
        end
      end
    end
  end

  // Receiver stall, plus the long hold when armed
  always @(posedge clk)
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);

  initial begin
    wait (hold_armed);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  function automatic stim_row_t ev_row(input logic [2:0] cmd, input logic [27:0] delta,
                                       input logic [3:0] chan, input logic [6:0] pitch,
                                       input logic [6:0] vel, input int n_typed = -1,
                                       input logic [63:0] typed = '0);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.regs = '0;
    r.ev.cmd = cmd;
    r.ev.delta_ticks = delta;
    r.ev.channel = chan;
    r.ev.pitch = pitch;
    r.ev.velocity = vel;
    r.n_typed = n_typed;
    r.typed = typed;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [14:0] bpm, input logic [14:0] ticks,
                                        input logic [14:0] beats, input logic [14:0] base);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.regs[CFG_TEMPO_BPM] = bpm;
    r.regs[CFG_TICKS_PER_BEAT] = ticks;
    r.regs[CFG_SIG_BEATS] = beats;
    r.regs[CFG_SIG_BASE] = base;
    r.ev = '0;
    r.n_typed = -1;
    r.typed = '0;
    return r;
  endfunction

  // Offer one event and hold it until it is taken
  task automatic send_event(input mte_in_t ev, input int n_exp, input logic [63:0] exp_bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    typed_n <= n_exp;
    typed_bytes <= exp_bytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait for the block to go quiet before touching the registers
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic program_regs(input logic [3:0][14:0] regs);
    logic [CFG_IDX_W-1:0] order[4];
    order = '{CFG_TEMPO_BPM, CFG_TICKS_PER_BEAT, CFG_SIG_BEATS, CFG_SIG_BASE};
    foreach (order[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data <= regs[order[k]];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    bpm_mirror = regs[CFG_TEMPO_BPM][9:0];
    ticks_mirror = regs[CFG_TICKS_PER_BEAT];
    beats_mirror = regs[CFG_SIG_BEATS][7:0];
    base_mirror = regs[CFG_SIG_BASE][7:0];
    settings_count++;
  endtask

  // Main sequence
  initial begin
    mte_in_t ev;
    int pick;
    logic [3:0][14:0] regs;
    int phase_send[5];
    int phase_stall[5];
    phase_send = '{0, 62, 0, 15, 0};
    phase_stall = '{0, 0, 62, 15, 0};

    // Directed table; reset values apply until the first register row
    directed_rows.push_back(ev_row(CMD_END, 28'd0, 4'd0, 7'd0, 7'd0, 4, 64'h00FF2F00_00000000));
    directed_rows.push_back(ev_row(CMD_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 7,
                                   64'h00FF5103_07A12000));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0, 8,
                                   64'h00FF5804_0402E008));
    directed_rows.push_back(ev_row(CMD_NOTE_ON, 28'd0, 4'd0, 7'd0, 7'd0, 4,
                                   64'h00900000_00000000));
    directed_rows.push_back(ev_row(CMD_NOTE_ON, 28'hFFF_FFFF, 4'hF, 7'h7F, 7'h7F, 7,
                                   64'hFFFFFF7F_9F7F7F00));
    directed_rows.push_back(ev_row(CMD_NOTE_OFF, 28'h7F, 4'd5, 7'h3C, 7'h64, 4,
                                   64'h7F853C00_00000000));
    directed_rows.push_back(ev_row(CMD_NOTE_ON, 28'h80, 4'd9, 7'h2A, 7'h55));
    directed_rows.push_back(ev_row(CMD_NOTE_OFF, 28'h3FFF, 4'd1, 7'h11, 7'h7F));
    directed_rows.push_back(ev_row(CMD_NOTE_ON, 28'h4000, 4'd14, 7'h40, 7'h01));
    directed_rows.push_back(ev_row(CMD_NOTE_ON, 28'h1F_FFFF, 4'd3, 7'h01, 7'h40));
    directed_rows.push_back(ev_row(CMD_NOTE_OFF, 28'h20_0000, 4'd10, 7'h7E, 7'h33));
    directed_rows.push_back(ev_row(3'd5, 28'h123_4567, 4'd2, 7'h10, 7'h20, 0));
    directed_rows.push_back(ev_row(3'd6, 28'd0, 4'd0, 7'd0, 7'd0, 0));
    directed_rows.push_back(ev_row(3'd7, 28'hFFF_FFFF, 4'hF, 7'h7F, 7'h7F, 0));
    // slow tempo, including zero, saturates
    directed_rows.push_back(cfg_row(15'd0, 15'd480, 15'd4, 15'd4));
    directed_rows.push_back(ev_row(CMD_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 7,
                                   64'h00FF5103_FFFFFF00));
    directed_rows.push_back(cfg_row(15'd3, 15'd480, 15'd4, 15'd4));
    directed_rows.push_back(ev_row(CMD_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 7,
                                   64'h00FF5103_FFFFFF00));
    directed_rows.push_back(cfg_row(15'd4, 15'd480, 15'd4, 15'd4));
    directed_rows.push_back(ev_row(CMD_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 7,
                                   64'h00FF5103_E4E1C000));
    // upper data bits dropped: tempo 1023
    directed_rows.push_back(cfg_row(15'h7FFF, 15'd480, 15'd4, 15'd4));
    directed_rows.push_back(ev_row(CMD_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0));
    // bad denominators give nothing
    directed_rows.push_back(cfg_row(15'd1000, 15'd480, 15'd4, 15'd3));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0, 0));
    directed_rows.push_back(cfg_row(15'd1000, 15'd480, 15'd4, 15'd0));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0, 0));
    // eighth-note base divides the clocks by three
    directed_rows.push_back(cfg_row(15'd500, 15'h7FFF, 15'd255, 15'd8));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0));
    directed_rows.push_back(cfg_row(15'd500, 15'd1, 15'd0, 15'd32));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0, 8,
                                   64'h00FF5804_00050108));
    directed_rows.push_back(cfg_row(15'd500, 15'h5555, 15'h7FAA, 15'h7F01));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0));
    directed_rows.push_back(cfg_row(15'd500, 15'd480, 15'd4, 15'h7FFF));
    directed_rows.push_back(ev_row(CMD_TIME_SIG, 28'd0, 4'd0, 7'd0, 7'd0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    stall_pct = 15;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_idle();
        program_regs(directed_rows[i].regs);
      end else begin
        send_event(directed_rows[i].ev, directed_rows[i].n_typed, directed_rows[i].typed);
      end
    end

    // Random traffic, one register setting and handshake mix per phase
    for (int phase = 0; phase < 5; phase++) begin
      drain_idle();
      regs[CFG_TEMPO_BPM] = {5'($urandom), ($urandom_range(9) == 0) ?
                             10'($urandom_range(3)) : 10'($urandom_range(1023, 4))};
      regs[CFG_TICKS_PER_BEAT] = 15'($urandom);
      regs[CFG_SIG_BEATS] = 15'($urandom);
      regs[CFG_SIG_BASE] = {7'($urandom), ($urandom_range(3) != 0) ?
                            8'(1 << $urandom_range(5)) : 8'($urandom)};
      program_regs(regs);
      send_idle_pct = phase_send[phase];
      stall_pct = phase_stall[phase];
      if (phase == 4) hold_armed <= 1'b1;   // back the block up from the output side
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      ev.cmd = CMD_NOTE_ON;
        else if (pick < 60) ev.cmd = CMD_NOTE_OFF;
        else if (pick < 70) ev.cmd = CMD_TEMPO;
        else if (pick < 85) ev.cmd = CMD_TIME_SIG;
        else if (pick < 93) ev.cmd = CMD_END;
        else                ev.cmd = 3'($urandom_range(7, 5));
        // spread delta over one to four groups
        case ($urandom_range(3))
          0:       ev.delta_ticks = 28'($urandom_range(127));
          1:       ev.delta_ticks = 28'($urandom_range(16383));
          2:       ev.delta_ticks = 28'($urandom_range(21'h1F_FFFF));
          default: ev.delta_ticks = 28'($urandom);
        endcase
        ev.channel = 4'($urandom);
        ev.pitch = 7'($urandom);
        ev.velocity = 7'($urandom);
        send_event(ev, -1, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    $display("Encoded %0d events (%0d with no output) across %0d register settings,",
             events_taken, events_silent, settings_count);
    $display("five handshake mixes and one long output hold; %0d bytes compared, %0d errors",
             bytes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ midi_track_event_encoder_core.f @@
hw/rtl/mte_pkg.sv
hw/rtl/mte_div.sv
hw/rtl/mte_front.sv
hw/rtl/mte_queue.sv
hw/rtl/mte_back.sv
hw/rtl/midi_track_event_encoder_core.sv
dv/midi_track_event_encoder_core_tb.sv
